// ----- hw/rtl/fpha_pkg.sv -----
// ----------------------------------------------------------------------------
// fpha_pkg
// Shared codes, state type and control structs of the hole allocator.
// ----------------------------------------------------------------------------
package fpha_pkg;

    // Operation codes; code 3 is a no-op
    localparam logic [1:0] OP_DEFINE = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_REWIND = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_ALLOC  = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [1:0] STATUS_DONE   = 2'd2;

    // Fit policies; code 3 behaves as first fit
    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fpha_state_t;

    // Table commands broadcast to every cell
    typedef struct packed {
        logic define_en;
        logic rewind_en;
        logic commit_en;
    } fpha_cmd_t;

    // Search token flags passed along the chain
    typedef struct packed {
        logic active;
        logic found;
    } fpha_flag_t;

endpackage

// ----- hw/rtl/fpha_req_if.sv -----
// ----------------------------------------------------------------------------
// fpha_req_if
// Request channel: valid/ready plus one operation.
// ----------------------------------------------------------------------------
interface fpha_req_if #(
    parameter int IDX_W  = 4,
    parameter int ADDR_W = 16
);
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [IDX_W-1:0]  hole_index;
    logic [ADDR_W-1:0] hole_start;
    logic [ADDR_W-1:0] hole_end;
    logic [ADDR_W:0]   request_size;

    modport source (
        output valid, opcode, hole_index, hole_start, hole_end, request_size,
        input  ready
    );

    modport sink (
        input  valid, opcode, hole_index, hole_start, hole_end, request_size,
        output ready
    );
endinterface

// ----- hw/rtl/fpha_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fpha_rsp_if
// Result channel: valid/ready plus one allocation result.
// ----------------------------------------------------------------------------
interface fpha_rsp_if #(
    parameter int IDX_W  = 4,
    parameter int ADDR_W = 16
);
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [IDX_W-1:0]  chosen_hole;
    logic [ADDR_W-1:0] placed_address;
    logic [ADDR_W:0]   space_left;

    modport source (
        output valid, status, chosen_hole, placed_address, space_left,
        input  ready
    );

    modport sink (
        input  valid, status, chosen_hole, placed_address, space_left,
        output ready
    );
endinterface

// ----- hw/rtl/fpha_cell.sv -----
// ----------------------------------------------------------------------------
// fpha_cell
// One hole of the table plus one registered stage of the search chain.
// ----------------------------------------------------------------------------
module fpha_cell #(
    parameter int IDX_W    = 4,
    parameter int ADDR_W   = 16,
    parameter int CELL_IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpha_pkg::fpha_cmd_t  cmd,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [ADDR_W-1:0]    wr_first,
    input  logic [ADDR_W-1:0]    wr_last,
    input  logic [IDX_W-1:0]     commit_idx,
    input  logic [ADDR_W:0]      commit_fill,
    input  logic [1:0]           policy,
    input  logic [ADDR_W:0]      need,
    input  fpha_pkg::fpha_flag_t tin_flag,
    input  logic [IDX_W-1:0]     tin_pick,
    input  logic [ADDR_W:0]      tin_space,
    input  logic [ADDR_W:0]      tin_fill,
    output fpha_pkg::fpha_flag_t tout_flag,
    output logic [IDX_W-1:0]     tout_pick,
    output logic [ADDR_W:0]      tout_space,
    output logic [ADDR_W:0]      tout_fill
);
    import fpha_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ADDR_W-1:0] first_reg;
    logic [ADDR_W-1:0] last_reg;
    logic [ADDR_W:0]   fill_reg;
    logic              valid_reg;

    fpha_flag_t        flag_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [ADDR_W:0]   space_reg;
    logic [ADDR_W:0]   pfill_reg;

    logic [ADDR_W:0]   top_addr;
    logic [ADDR_W:0]   free_units;
    logic              fits;
    logic              take;

    // free = last + 1 - fill, floored at zero
    always_comb
    begin
        top_addr   = {1'b0, last_reg} + (ADDR_W+1)'(1);
        free_units = (top_addr > fill_reg) ? (top_addr - fill_reg) : '0;
        fits       = valid_reg && (free_units >= need);
        unique case (policy)
            POLICY_BEST:  take = fits && (!tin_flag.found || free_units <= tin_space);
            POLICY_WORST: take = fits && (!tin_flag.found || free_units >= tin_space);
            default:      take = fits && !tin_flag.found;
        endcase
        take = take && tin_flag.active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.define_en && wr_idx == MY_IDX)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.define_en && wr_idx == MY_IDX)
        begin
            first_reg <= wr_first;
            last_reg  <= wr_last;
            fill_reg  <= {1'b0, wr_first};
        end
        else if (cmd.rewind_en)
        begin
            fill_reg <= {1'b0, first_reg};
        end
        else if (cmd.commit_en && commit_idx == MY_IDX)
        begin
            fill_reg <= commit_fill;
        end
    end

    // Chain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
        end
        else
        begin
            flag_reg.active <= tin_flag.active;
            flag_reg.found  <= tin_flag.found || take;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg  <= take ? MY_IDX     : tin_pick;
        space_reg <= take ? free_units : tin_space;
        pfill_reg <= take ? fill_reg   : tin_fill;
    end

    assign tout_flag  = flag_reg;
    assign tout_pick  = pick_reg;
    assign tout_space = space_reg;
    assign tout_fill  = pfill_reg;

endmodule

// ----- hw/rtl/fit_policy_hole_allocator.sv -----
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator
// Hole-table memory allocator with first, best and worst fit policies.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    opcode, hole_index, hole_start, hole_end,
//                               request_size
// rsp       out  valid/ready    status, chosen_hole, placed_address, space_left
// cfg       in   cfg_we         cfg_wdata = fit_policy
//
// Define, rewind and no-op pass through the final state to the output
// register; an allocate first passes the scan state, where the search
// token walks the chain of cells one hole per cycle. One operation is in
// flight at a time; req.ready is high only when idle. The result sits in an
// output register, so a new request is taken while it waits. A stalled rsp
// holds the block in its final state. Reset clears the valid bits, the
// policy and the control state; hole contents are undefined until defined.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator #(
    parameter int NUM_HOLES = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    fpha_req_if.sink    req,
    fpha_rsp_if.source  rsp
);
    import fpha_pkg::*;

    localparam int IDX_W  = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
    localparam int ADDR_W = ADDR_BITS;

    // Configuration
    logic [1:0] policy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIRST;
        end
        else if (cfg_we)
        begin
            policy_reg <= cfg_wdata;
        end
    end

    // Control state
    fpha_state_t state_reg, state_next;
    logic        alloc_reg;
    logic [ADDR_W:0] need_reg;

    // Result of the search, captured as the token leaves the last cell
    logic             found_reg;
    logic [IDX_W-1:0] pick_reg;
    logic [ADDR_W:0]  space_reg;
    logic [ADDR_W:0]  fill_reg;

    // Output register
    logic              rsp_valid_reg;
    logic [1:0]        status_reg;
    logic [IDX_W-1:0]  chosen_reg;
    logic [ADDR_W-1:0] placed_reg;
    logic [ADDR_W:0]   left_reg;

    logic accept;
    logic head_active;
    logic slot_free;
    logic capture;
    logic load_out;
    logic [ADDR_W:0] need_bus;
    logic [ADDR_W:0] new_fill;
    logic [ADDR_W:0] units_left;
    fpha_cmd_t cmd;

    // Search chain: entry 0 is the head, entry i+1 the output of cell i
    fpha_flag_t       chain_flag  [NUM_HOLES+1];
    logic [IDX_W-1:0] chain_pick  [NUM_HOLES+1];
    logic [ADDR_W:0]  chain_space [NUM_HOLES+1];
    logic [ADDR_W:0]  chain_fill  [NUM_HOLES+1];
    logic [NUM_HOLES-1:0] active_vec;

    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign head_active = accept && (req.opcode == OP_ALLOC);
    assign slot_free   = !rsp_valid_reg || rsp.ready;

    // The request size feeds cell 0 on the accept cycle, the held copy after
    assign need_bus = head_active ? req.request_size : need_reg;

    assign chain_flag[0]  = '{active: head_active, found: 1'b0};
    assign chain_pick[0]  = '0;
    assign chain_space[0] = '0;
    assign chain_fill[0]  = '0;

    // Commit arithmetic for the picked hole
    assign new_fill   = fill_reg + need_reg;
    assign units_left = space_reg - need_reg;

    always_comb
    begin
        state_next    = state_reg;
        capture       = 1'b0;
        load_out      = 1'b0;
        cmd.define_en = accept && (req.opcode == OP_DEFINE);
        cmd.rewind_en = accept && (req.opcode == OP_REWIND);
        cmd.commit_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.opcode == OP_ALLOC) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (chain_flag[NUM_HOLES].active)
                begin
                    capture    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    load_out      = 1'b1;
                    cmd.commit_en = alloc_reg && found_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            alloc_reg <= (req.opcode == OP_ALLOC);
            need_reg  <= req.request_size;
            found_reg <= 1'b0;
        end
        if (capture)
        begin
            found_reg <= chain_flag[NUM_HOLES].found;
            pick_reg  <= chain_pick[NUM_HOLES];
            space_reg <= chain_space[NUM_HOLES];
            fill_reg  <= chain_fill[NUM_HOLES];
        end
        if (load_out)
        begin
            if (alloc_reg && found_reg)
            begin
                status_reg <= STATUS_ALLOC;
                chosen_reg <= pick_reg;
                placed_reg <= fill_reg[ADDR_W-1:0];
                left_reg   <= units_left;
            end
            else
            begin
                status_reg <= alloc_reg ? STATUS_NO_FIT : STATUS_DONE;
                chosen_reg <= '0;
                placed_reg <= '0;
                left_reg   <= '0;
            end
        end
    end

    // Row of hole cells
    for (genvar i = 0; i < NUM_HOLES; i++)
    begin : g_cell
        fpha_cell #(
            .IDX_W    (IDX_W),
            .ADDR_W   (ADDR_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .wr_idx      (req.hole_index),
            .wr_first    (req.hole_start),
            .wr_last     (req.hole_end),
            .commit_idx  (pick_reg),
            .commit_fill (new_fill),
            .policy      (policy_reg),
            .need        (need_bus),
            .tin_flag    (chain_flag[i]),
            .tin_pick    (chain_pick[i]),
            .tin_space   (chain_space[i]),
            .tin_fill    (chain_fill[i]),
            .tout_flag   (chain_flag[i+1]),
            .tout_pick   (chain_pick[i+1]),
            .tout_space  (chain_space[i+1]),
            .tout_fill   (chain_fill[i+1])
        );
        assign active_vec[i] = chain_flag[i+1].active;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.chosen_hole    = chosen_reg;
    assign rsp.placed_address = placed_reg;
    assign rsp.space_left     = left_reg;

`ifndef SYNTH
    // Only one search token may be in the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(active_vec))
        else $error("more than one search token in the chain");

    // The token leaves the chain only while the controller waits for it
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_flag[NUM_HOLES].active |-> state_reg == ST_SCAN)
        else $error("search token left the chain outside the scan");

    // A new result is only raised from the final state
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the final state");

    // Non-allocated results carry zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg != STATUS_ALLOC
        |-> chosen_reg == '0 && placed_reg == '0 && left_reg == '0)
        else $error("non-zero payload on a result without allocation");
`endif

endmodule

// ----- tb/fit_policy_hole_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator_tb
// Self-checking bench for the hole-table allocator. Request transfers are
// mirrored into a predictor that keeps its own hole table and fit policy.
// Each result transfer is checked, field by field, against the oldest
// predicted result. The directed opening covers empty tables, inverted and
// full holes, zero-size and oversized requests, the spare opcode and policy
// code, and ties. Random rounds then define holes and allocate against them.
// Both channels idle in random bursts, and the result side is held off once.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator_tb;

    import fpha_pkg::*;

    // Spare codes with no name in the package: opcode 3 is a no-op and
    // policy 3 falls back to first fit
    localparam logic [1:0] OP_NOP       = 2'd3;
    localparam logic [1:0] POLICY_ALIAS = 2'd3;

    localparam int NUM_HOLES   = 16;
    localparam int PHASE_ITEMS = 210;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 20;      // allocate latency plus margin
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  hole;
        logic [15:0] addr;
        logic [16:0] space;
    } alloc_result_t;

    // ------------------------------------------------------------------------
    // Predictor and store of expected results
    // ------------------------------------------------------------------------
    class alloc_scoreboard;
        logic [1:0]    policy;
        logic [15:0]   first_addr [NUM_HOLES];
        logic [15:0]   last_addr  [NUM_HOLES];
        logic [16:0]   fill_ptr   [NUM_HOLES];
        bit            hole_live  [NUM_HOLES];
        alloc_result_t awaited_q [$];
        int            errors;

        function new();
            policy = POLICY_FIRST;
            errors = 0;
            for (int h = 0; h < NUM_HOLES; h++)
            begin
                first_addr[h] = '0;
                last_addr[h]  = '0;
                fill_ptr[h]   = '0;
                hole_live[h]  = 1'b0;
            end
        endfunction

        // last - fill + 1, floored at zero (inverted or overfilled hole)
        function logic [16:0] free_units(int h);
            logic [16:0] top;
            top = {1'b0, last_addr[h]} + 17'd1;
            return (top > fill_ptr[h]) ? top - fill_ptr[h] : 17'd0;
        endfunction

        function logic [16:0] space_of(int h);
            return hole_live[h] ? free_units(h) : 17'd0;
        endfunction

        function int outstanding();
            return awaited_q.size();
        endfunction

        function void note_request(logic [1:0] op, logic [3:0] idx,
                                   logic [15:0] fa, logic [15:0] la,
                                   logic [16:0] need);
            alloc_result_t r;
            bit            found;
            int            pick;
            logic [16:0]   pick_space;
            logic [16:0]   sp;
            r          = '0;
            r.status   = STATUS_DONE;
            found      = 1'b0;
            pick       = 0;
            pick_space = '0;
            case (op)
                OP_DEFINE:
                begin
                    first_addr[idx] = fa;
                    last_addr[idx]  = la;
                    fill_ptr[idx]   = {1'b0, fa};
                    hole_live[idx]  = 1'b1;
                end
                OP_REWIND:
                begin
                    for (int h = 0; h < NUM_HOLES; h++)
                        fill_ptr[h] = {1'b0, first_addr[h]};
                end
                OP_ALLOC:
                begin
                    for (int h = 0; h < NUM_HOLES; h++)
                    begin
                        if (!hole_live[h])
                            continue;
                        sp = free_units(h);
                        if (sp < need)
                            continue;
                        // best and worst fit: ties go to the later hole
                        if (policy == POLICY_BEST)
                        begin
                            if (!found || sp <= pick_space)
                            begin
                                found = 1'b1; pick = h; pick_space = sp;
                            end
                        end
                        else if (policy == POLICY_WORST)
                        begin
                            if (!found || sp >= pick_space)
                            begin
                                found = 1'b1; pick = h; pick_space = sp;
                            end
                        end
                        else
                        begin
                            found = 1'b1; pick = h; pick_space = sp;
                            break;
                        end
                    end
                    if (found)
                    begin
                        r.status       = STATUS_ALLOC;
                        r.hole         = pick[3:0];
                        r.addr         = fill_ptr[pick][15:0];
                        fill_ptr[pick] = fill_ptr[pick] + need;
                        r.space        = pick_space - need;
                    end
                    else
                        r.status = STATUS_NO_FIT;
                end
                default: ;
            endcase
            awaited_q.insert(awaited_q.size(), r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(alloc_result_t got);
            alloc_result_t want;
            if (awaited_q.size() == 0)
            begin
                report($sformatf("result transfer with nothing awaited (status %0d)",
                                 got.status));
                return;
            end
            want = awaited_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.hole !== want.hole)
                report($sformatf("chosen_hole %0d, want %0d", got.hole, want.hole));
            if (got.addr !== want.addr)
                report($sformatf("placed_address %0h, want %0h", got.addr, want.addr));
            if (got.space !== want.space)
                report($sformatf("space_left %0h, want %0h", got.space, want.space));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    fpha_req_if #(.IDX_W(4), .ADDR_W(16)) req_ch ();
    fpha_rsp_if #(.IDX_W(4), .ADDR_W(16)) rsp_ch ();

    fit_policy_hole_allocator #(
        .NUM_HOLES (NUM_HOLES),
        .ADDR_BITS (16)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    alloc_scoreboard sb = new();

    // Idling controls, owned by the main sequence
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_request;   // asks the result side for one long hold-off
    int sent_count;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a run that never drains ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: sample at the rising edge, drive ready at the falling edge.
    // Random stall bursts, plus the long hold-off, which is counted here so the
    // request side keeps offering meanwhile.
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int stall_left;
        int hold_left;
        alloc_result_t got;
        stall_left   = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status = rsp_ch.status;
                got.hole   = rsp_ch.chosen_hole;
                got.addr   = rsp_ch.placed_address;
                got.space  = rsp_ch.space_left;
                sb.check_result(got);
            end
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left   = $urandom_range(0, 4);
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Entered and left at a falling edge; valid is left high
    // after a transfer so back-to-back items keep it up without a dip.
    // ------------------------------------------------------------------------
    task automatic send_op(logic [1:0] op, logic [3:0] idx, logic [15:0] fa,
                           logic [15:0] la, logic [16:0] need);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.opcode       = op;
        req_ch.hole_index   = idx;
        req_ch.hole_start   = fa;
        req_ch.hole_end     = la;
        req_ch.request_size = need;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(op, idx, fa, la, need);
        sent_count++;
        @(negedge clk);
    endtask

    // Don't-care fields get random values so their bits still toggle
    task automatic send_alloc(logic [16:0] need);
        send_op(OP_ALLOC, 4'($urandom), 16'($urandom), 16'($urandom), need);
    endtask

    task automatic send_define(logic [3:0] idx, logic [15:0] fa, logic [15:0] la);
        send_op(OP_DEFINE, idx, fa, la, 17'($urandom));
    endtask

    // Idle point: request side quiet, every result in, then a short settle
    task automatic drain();
        req_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_policy(logic [1:0] p);
        cfg_we    = 1'b1;
        cfg_wdata = p;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.policy = p;
    endtask

    // One well-formed round: a few holes, then allocations sized against
    // them, with the odd rewind or spare opcode mixed in
    task automatic run_round();
        int          n_def;
        int          n_alloc;
        int          kind;
        bit          same_len;
        logic [16:0] shared_len;
        logic [16:0] len;
        logic [16:0] top;
        logic [15:0] fa;
        logic [15:0] la;
        n_def      = $urandom_range(2, 6);
        n_alloc    = $urandom_range(3, 12);
        same_len   = ($urandom_range(0, 2) == 0);   // provokes policy ties
        shared_len = 17'($urandom_range(0, 300));
        for (int i = 0; i < n_def; i++)
        begin
            fa = 16'($urandom);
            if (same_len)
                len = shared_len;
            else if ($urandom_range(0, 9) == 0)
                len = 17'($urandom_range(0, 65535));
            else
                len = 17'($urandom_range(0, 400));
            top = {1'b0, fa} + len;
            la  = (top > 17'd65535) ? 16'hFFFF : top[15:0];
            if ($urandom_range(0, 19) == 0)
                la = 16'($urandom);                 // may come out inverted
            send_define(4'($urandom), fa, la);
        end
        for (int i = 0; i < n_alloc; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 6)
                send_alloc(17'd0);
            else if (kind < 30)
                send_alloc(sb.space_of($urandom_range(0, NUM_HOLES - 1)));
            else if (kind < 88)
                send_alloc(17'($urandom_range(1, 150)));
            else if (kind < 93)
                send_alloc(17'($urandom));
            else if (kind < 97)
                send_op(OP_REWIND, 4'($urandom), 16'($urandom), 16'($urandom),
                        17'($urandom));
            else
                send_op(OP_NOP, 4'($urandom), 16'($urandom), 16'($urandom),
                        17'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [1:0] plan [8];
        int         target;
        plan = '{POLICY_BEST, POLICY_WORST, POLICY_ALIAS, POLICY_FIRST,
                 POLICY_WORST, POLICY_BEST, POLICY_ALIAS, POLICY_WORST};

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = POLICY_FIRST;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_DEFINE;
        req_ch.hole_index   = '0;
        req_ch.hole_start   = '0;
        req_ch.hole_end     = '0;
        req_ch.request_size = '0;
        tx_idle_on          = 1'b0;
        rx_idle_on          = 1'b0;
        hold_request        = 1'b0;
        sent_count          = 0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed, first fit from reset ---
        set_policy(POLICY_FIRST);
        send_alloc(17'd1);                          // empty table: no fit
        send_alloc(17'd0);                          // zero size, still no hole
        send_op(OP_NOP, 4'hF, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
        send_op(OP_REWIND, 4'h0, 16'h0, 16'h0, 17'h0);
        send_define(4'd0, 16'h0000, 16'hFFFF);      // whole address space
        send_define(4'd15, 16'hFFFF, 16'h0000);     // inverted: no space
        send_define(4'd5, 16'd100, 16'd199);
        send_define(4'd9, 16'd1000, 16'd1099);      // same size as hole 5
        send_alloc(17'h10000);                      // fills hole 0 exactly
        send_alloc(17'd0);                          // fits the full hole 0
        send_alloc(17'd1);
        send_alloc(17'h1FFFF);                      // larger than any hole
        send_op(OP_REWIND, 4'h0, 16'h0, 16'h0, 17'h0);
        send_alloc(17'd100);

        // --- best fit: tie between holes 5 and 9, then zero-size on empties ---
        drain();
        set_policy(POLICY_BEST);
        send_alloc(17'd100);
        send_alloc(17'd100);
        send_alloc(17'd0);
        send_alloc(17'd1);

        // --- worst fit, then the spare policy code ---
        drain();
        set_policy(POLICY_WORST);
        send_alloc(17'd5);
        send_alloc(17'd0);
        drain();
        set_policy(POLICY_ALIAS);
        send_alloc(17'd1);
        send_alloc(17'd65000);

        // --- random phases, one policy each; the last one runs without gaps ---
        for (int p = 0; p < 8; p++)
        begin
            drain();
            set_policy(plan[p]);
            target = sent_count + PHASE_ITEMS;
            if (p == 1)
                hold_request = 1'b1;                // long hold-off, sender keeps going
            while (sent_count < target)
            begin
                tx_idle_on = (p != 7) && ($urandom_range(0, 3) != 0);
                rx_idle_on = (p != 7) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) < 8)
                    run_round();
                else
                    send_op(2'($urandom), 4'($urandom), 16'($urandom),
                            16'($urandom), 17'($urandom));
            end
        end

        req_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/fpha_pkg.sv
hw/rtl/fpha_req_if.sv
hw/rtl/fpha_rsp_if.sv
hw/rtl/fpha_cell.sv
hw/rtl/fit_policy_hole_allocator.sv
tb/fit_policy_hole_allocator_tb.sv
